FILE: design/qte_pkg.sv
// Shared types, constants and helpers of the quaternion to Euler angle converter.
// No dependencies; every other design file but qte_delay refers to it by scoped names.
package qte_pkg;

  // Default number of CORDIC micro-rotations
  localparam int unsigned CordicStagesDef = 16;

  // Widths of the fixed-point values
  localparam int unsigned QuatW     = 16;  // Q1.14 input component
  localparam int unsigned ProdW     = 32;  // product of two components, Q.28
  localparam int unsigned OpW       = 34;  // atan2 operand, Q.28
  localparam int unsigned TW        = 30;  // clamped pitch sine, Q.28
  localparam int unsigned RadW      = 57;  // 1 - t^2, Q.56
  localparam int unsigned SqW       = 29;  // floor square root, Q.28
  localparam int unsigned SqrtSteps = 29;  // one root bit per step
  localparam int unsigned CxW       = 37;  // CORDIC vector with gain headroom
  localparam int unsigned AngW      = 28;  // angle accumulator, Q.24
  localparam int unsigned RollW     = 16;  // Q2.13 output
  localparam int unsigned PitchW    = 15;  // Q1.13 output

  localparam logic signed [OpW-1:0]  OneQ28  = 34'sd268435456;
  localparam logic signed [AngW-1:0] PiQ24   = 28'sd52707179;
  localparam logic signed [RollW-1:0] PiQ13   = 16'sd25736;
  localparam logic signed [RollW-1:0] HalfPiQ13 = 16'sd12868;
  localparam logic [RadW-1:0] OneQ56 = {1'b1, {(RadW-1){1'b0}}};

  // Word passed from the front end to the back end through the queue
  typedef struct packed {
    logic signed [OpW-1:0] roll_num;
    logic signed [OpW-1:0] roll_den;
    logic signed [OpW-1:0] yaw_num;
    logic signed [OpW-1:0] yaw_den;
    logic signed [TW-1:0]  tval;
  } qte_word_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } qte_qstat_t;

  // Arctangent of 2^-idx in Q.24, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_q24(input int unsigned idx);
    logic signed [AngW-1:0] r;
    unique case (idx)
      0:  r = 28'sd13176795;
      1:  r = 28'sd7778716;
      2:  r = 28'sd4110060;
      3:  r = 28'sd2086331;
      4:  r = 28'sd1047214;
      5:  r = 28'sd524117;
      6:  r = 28'sd262123;
      7:  r = 28'sd131069;
      8:  r = 28'sd65536;
      9:  r = 28'sd32768;
      10: r = 28'sd16384;
      11: r = 28'sd8192;
      12: r = 28'sd4096;
      13: r = 28'sd2048;
      14: r = 28'sd1024;
      15: r = 28'sd512;
      16: r = 28'sd256;
      17: r = 28'sd128;
      18: r = 28'sd64;
      19: r = 28'sd32;
      20: r = 28'sd16;
      21: r = 28'sd8;
      22: r = 28'sd4;
      23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round a Q.24 angle to Q2.13 (half up) and saturate to +/- lim
  function automatic logic signed [RollW-1:0] to_q13(input logic signed [AngW-1:0] ang,
                                                     input logic signed [RollW-1:0] lim);
    logic signed [AngW:0]    sum;
    logic signed [AngW-11:0] shr;
    logic signed [RollW-1:0] r;
    sum = (AngW+1)'(ang) + (AngW+1)'(1024);
    shr = sum[AngW:11];
    if (shr > (AngW-10)'(lim)) begin
      r = lim;
    end else if (shr < -(AngW-10)'(lim)) begin
      r = -lim;
    end else begin
      r = shr[RollW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/qte_front.sv
// Front end: takes quaternion words, forms the products and the atan2 operands.
// Depends on qte_pkg; feeds qte_queue.
module qte_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [qte_pkg::QuatW-1:0]  quat_x_i,
  input  logic signed [qte_pkg::QuatW-1:0]  quat_y_i,
  input  logic signed [qte_pkg::QuatW-1:0]  quat_z_i,
  input  logic signed [qte_pkg::QuatW-1:0]  quat_w_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  qte_pkg::qte_qstat_t               qstat_i,
  output logic                              push_o,
  output qte_pkg::qte_word_t                word_o
);

  logic signed [qte_pkg::ProdW-1:0] xw_q, yz_q, yw_q, xz_q, xy_q, zw_q, xx_q, yy_q, zz_q;
  logic s1_v_q, s2_v_q;
  logic adv;
  qte_pkg::qte_word_t word_d, word_q;
  logic signed [qte_pkg::OpW-1:0] t_full;

  // Advance when the last stage is empty or the queue can take it
  assign adv        = !s2_v_q || !qstat_i.full;
  assign in_ready_o = adv;
  assign push_o     = s2_v_q && !qstat_i.full;
  assign word_o     = word_q;

  // Hold valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  // Register the component products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xw_q <= quat_x_i * quat_w_i;
      yz_q <= quat_y_i * quat_z_i;
      yw_q <= quat_y_i * quat_w_i;
      xz_q <= quat_x_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zw_q <= quat_z_i * quat_w_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // Form the atan2 operands and clamp the pitch sine
  always_comb begin
    word_d.roll_num = (qte_pkg::OpW'(xw_q) + qte_pkg::OpW'(yz_q)) <<< 1;
    word_d.roll_den = qte_pkg::OneQ28 - ((qte_pkg::OpW'(xx_q) + qte_pkg::OpW'(yy_q)) <<< 1);
    word_d.yaw_num  = (qte_pkg::OpW'(xy_q) + qte_pkg::OpW'(zw_q)) <<< 1;
    word_d.yaw_den  = qte_pkg::OneQ28 - ((qte_pkg::OpW'(yy_q) + qte_pkg::OpW'(zz_q)) <<< 1);
    t_full          = (qte_pkg::OpW'(yw_q) - qte_pkg::OpW'(xz_q)) <<< 1;
    if (t_full > qte_pkg::OneQ28) begin
      word_d.tval = qte_pkg::TW'(qte_pkg::OneQ28);
    end else if (t_full < -qte_pkg::OneQ28) begin
      word_d.tval = qte_pkg::TW'(-qte_pkg::OneQ28);
    end else begin
      word_d.tval = t_full[qte_pkg::TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      word_q <= word_d;
    end
  end

endmodule

FILE: design/qte_queue.sv
// Four-entry queue between the front end and the back end.
// Depends on qte_pkg for the word and status types.
module qte_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qte_pkg::qte_word_t  word_i,
  input  logic                pop_i,
  output qte_pkg::qte_word_t  word_o,
  output qte_pkg::qte_qstat_t qstat_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  qte_pkg::qte_word_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign qstat_o.full  = (cnt_q == (PtrW+1)'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign word_o        = mem_q[rd_ptr_q];

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

FILE: design/qte_sqrt.sv
// Pipelined floor square root, one root bit per stage (digit recurrence).
// Depends on qte_pkg for widths.
module qte_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qte_pkg::RadW-1:0]  rad_i,
  output logic [qte_pkg::SqW-1:0]   root_o
);

  localparam int unsigned N = qte_pkg::SqrtSteps;
  localparam int unsigned W = qte_pkg::RadW;

  logic [W-1:0] rem_q [N];
  logic [W:0]   res_q [N];
  logic [W-1:0] rem_in [N];
  logic [W:0]   res_in [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [W:0] BitVal = (W+1)'(1) << (2 * (N - 1 - j));
    logic [W:0] trial;

    if (j == 0) begin : g_first
      assign rem_in[j] = rad_i;
      assign res_in[j] = '0;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign res_in[j] = res_q[j-1];
    end

    assign trial = res_in[j] + BitVal;

    // Subtract the trial value where it fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, rem_in[j]} >= trial) begin
          rem_q[j] <= rem_in[j] - trial[W-1:0];
          res_q[j] <= (res_in[j] >> 1) + BitVal;
        end else begin
          rem_q[j] <= rem_in[j];
          res_q[j] <= res_in[j] >> 1;
        end
      end
    end
  end

  assign root_o = res_q[N-1][qte_pkg::SqW-1:0];

endmodule

FILE: design/qte_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in Q.24.
// Depends on qte_pkg for widths, pi and the arctangent table.
module qte_cordic #(
  parameter int unsigned STAGES = qte_pkg::CordicStagesDef
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [qte_pkg::OpW-1:0]   y_i,
  input  logic signed [qte_pkg::OpW-1:0]   x_i,
  output logic signed [qte_pkg::AngW-1:0]  ang_o
);

  localparam int unsigned XW = qte_pkg::CxW;
  localparam int unsigned AW = qte_pkg::AngW;

  logic signed [XW-1:0] x_q [STAGES+1];
  logic signed [XW-1:0] y_q [STAGES+1];
  logic signed [AW-1:0] ang_q [STAGES+1];
  logic                 zero_q [STAGES+1];

  // Turn the vector by pi when x is negative
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0]   <= -XW'(x_i);
        y_q[0]   <= -XW'(y_i);
        ang_q[0] <= (y_i >= 0) ? qte_pkg::PiQ24 : -qte_pkg::PiQ24;
      end else begin
        x_q[0]   <= XW'(x_i);
        y_q[0]   <= XW'(y_i);
        ang_q[0] <= '0;
      end
    end
  end

  // Rotate toward the x axis, one micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] Step = qte_pkg::atan_q24(i);
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + dx;
          y_q[i+1]   <= y_q[i] - dy;
          ang_q[i+1] <= ang_q[i] + Step;
        end else begin
          x_q[i+1]   <= x_q[i] - dx;
          y_q[i+1]   <= y_q[i] + dy;
          ang_q[i+1] <= ang_q[i] - Step;
        end
      end
    end
  end

  // A zero vector has angle zero
  assign ang_o = zero_q[STAGES] ? '0 : ang_q[STAGES];

endmodule

FILE: design/qte_delay.sv
// Enabled shift line that keeps side values aligned with the back-end pipeline.
// No package dependency.
module qte_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  // Shift one place per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

FILE: design/quaternion_to_euler_unit.sv
// Quaternion to Z-Y-X Euler angles.
// Throughput: one word per cycle while neither the queue nor the output stalls; the back end
// runs the 29-step square root beside the roll and yaw CORDIC pipelines, with the pitch CORDIC
// after the root, all advancing one stage per cycle whenever the back end is enabled.
// Reset clears the valid bits and the queue pointers and count only; no other state.
// Depends on qte_pkg, qte_front, qte_queue, qte_sqrt, qte_cordic, qte_delay.
module quaternion_to_euler_unit #(
  parameter int unsigned CORDIC_STAGES = qte_pkg::CordicStagesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [qte_pkg::QuatW-1:0]     quat_x_i,
  input  logic signed [qte_pkg::QuatW-1:0]     quat_y_i,
  input  logic signed [qte_pkg::QuatW-1:0]     quat_z_i,
  input  logic signed [qte_pkg::QuatW-1:0]     quat_w_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  output logic signed [qte_pkg::RollW-1:0]     roll_angle_o,
  output logic signed [qte_pkg::PitchW-1:0]    pitch_angle_o,
  output logic signed [qte_pkg::RollW-1:0]     yaw_angle_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i
);

  localparam int unsigned SideDly  = qte_pkg::SqrtSteps + 1;
  localparam int unsigned ChainLen = qte_pkg::SqrtSteps + 3 + CORDIC_STAGES;
  localparam int unsigned AW       = qte_pkg::AngW;

  qte_pkg::qte_word_t   f_word, q_word, a_q;
  qte_pkg::qte_qstat_t  qstat;
  logic                 push, pop, back_en;
  logic [ChainLen-1:0]  vld_q;
  logic [qte_pkg::RadW-1:0]     rad_q;
  logic signed [2*qte_pkg::TW-1:0] tsq;
  logic [qte_pkg::SqW-1:0]      root;
  logic [qte_pkg::TW-1:0]       t_dly;
  logic signed [AW-1:0] roll_ang, yaw_ang, pitch_ang, roll_dly, yaw_dly;
  logic signed [qte_pkg::RollW-1:0] pitch_wide;
  logic out_valid_q;
  logic signed [qte_pkg::RollW-1:0]  roll_q, yaw_q;
  logic signed [qte_pkg::PitchW-1:0] pitch_q;

  qte_front u_front (
    .clk_i, .rst_ni, .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .in_valid_i, .in_ready_o,
    .qstat_i (qstat),
    .push_o  (push),
    .word_o  (f_word)
  );

  qte_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .word_i  (f_word),
    .pop_i   (pop),
    .word_o  (q_word),
    .qstat_o (qstat)
  );

  // Back end moves as one pipeline whenever the output slot frees up
  assign back_en = !out_valid_q || out_ready_i;
  assign pop     = back_en && !qstat.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (back_en) begin
      vld_q       <= {vld_q[ChainLen-2:0], pop};
      out_valid_q <= vld_q[ChainLen-1];
    end
  end

  // Load the head word, then form 1 - t^2
  assign tsq = a_q.tval * a_q.tval;

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      a_q   <= q_word;
      rad_q <= qte_pkg::OneQ56 - tsq[qte_pkg::RadW-1:0];
    end
  end

  qte_sqrt u_sqrt (
    .clk_i,
    .en_i   (back_en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  qte_delay #(.W(qte_pkg::TW), .DEPTH(SideDly)) u_t_dly (
    .clk_i, .en_i (back_en), .d_i (a_q.tval), .q_o (t_dly)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk_i, .en_i (back_en), .y_i (a_q.roll_num), .x_i (a_q.roll_den), .ang_o (roll_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i, .en_i (back_en), .y_i (a_q.yaw_num), .x_i (a_q.yaw_den), .ang_o (yaw_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i, .en_i (back_en),
    .y_i   (qte_pkg::OpW'($signed(t_dly))),
    .x_i   ($signed(qte_pkg::OpW'(root))),
    .ang_o (pitch_ang)
  );

  // Hold roll and yaw until the pitch path catches up
  qte_delay #(.W(AW), .DEPTH(SideDly)) u_roll_dly (
    .clk_i, .en_i (back_en), .d_i (roll_ang), .q_o (roll_dly)
  );

  qte_delay #(.W(AW), .DEPTH(SideDly)) u_yaw_dly (
    .clk_i, .en_i (back_en), .d_i (yaw_ang), .q_o (yaw_dly)
  );

  // Round and saturate into the output register
  assign pitch_wide = qte_pkg::to_q13(pitch_ang, qte_pkg::HalfPiQ13);

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      roll_q  <= qte_pkg::to_q13(roll_dly, qte_pkg::PiQ13);
      yaw_q   <= qte_pkg::to_q13(yaw_dly, qte_pkg::PiQ13);
      pitch_q <= pitch_wide[qte_pkg::PitchW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

  // A popped word enters the first back-end stage
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> vld_q[0])
    else $error("popped word did not enter the back end");

  // A stalled back end keeps its valid bits
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_en |=> $stable(vld_q))
    else $error("back end moved while stalled");

  // Queue never takes a word while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full))
    else $error("queue overflow");

  // Pitch stays within half pi
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o <= 15'sd12868) && (pitch_angle_o >= -15'sd12868))
    else $error("pitch out of range");

  // Roll stays within pi
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_angle_o <= 16'sd25736) && (roll_angle_o >= -16'sd25736))
    else $error("roll out of range");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for quaternion_to_euler_unit: random and directed quaternions,
// predicted angles compared word by word. Depends on qte_pkg and the design sources.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Stages = qte_pkg::CordicStagesDef;
  localparam longint OneQ28 = 64'sd1 << 28;
  localparam longint PiQ24 = 64'sd52707179;
  localparam int NumRandom = 1030;

  typedef struct {
    logic signed [15:0] x, y, z, w;
  } quat_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] roll_angle_o, yaw_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;

  quat_t pending_quats[$];
  euler_t expected_angles[$];
  int fail_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit stimulus_done = 1'b0;
  bit hold_sender = 1'b0;
  bit hold_receiver = 1'b0;

  quaternion_to_euler_unit dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Arctangent of 2^-i in Q.24
  function automatic longint atan_step(int i);
    longint tbl[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                        131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  // Vectoring rotation: angle of (xv, yv) in Q.24
  function automatic longint vector_angle(longint yv, longint xv);
    longint ang, dx, dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      ang = (yv >= 0) ? PiQ24 : -PiQ24;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += atan_step(i);
      end else begin
        xv -= dx; yv += dy; ang -= atan_step(i);
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_sat(longint a, longint lim);
    longint r;
    r = (a + 1024) >>> 11;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint x, y, z, w, t, r;
    longint unsigned s;
    euler_t e;
    x = q.x; y = q.y; z = q.z; w = q.w;
    r = round_sat(vector_angle(2 * (x * w + y * z), OneQ28 - 2 * (x * x + y * y)), 25736);
    e.roll = r[15:0];
    t = 2 * (y * w - x * z);
    if (t > OneQ28) t = OneQ28;
    if (t < -OneQ28) t = -OneQ28;
    s = floor_root((64'd1 << 56) - longint'(t * t));
    r = round_sat(vector_angle(t, longint'(s)), 12868);
    e.pitch = r[14:0];
    r = round_sat(vector_angle(2 * (x * y + z * w), OneQ28 - 2 * (y * y + z * z)), 25736);
    e.yaw = r[15:0];
    return e;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] rand_comp();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 16'($urandom);
    if (p == 1) return 16'($urandom_range(0, 32768) - 16384);
    return 16'(int'($urandom_range(0, 24000)) - 12000);
  endfunction

  // Scale a random direction to roughly unit length, sign varied
  function automatic quat_t rand_unit();
    quat_t q;
    real a, b, c, d, n;
    a = real'($urandom_range(0, 20000)) - 10000.0;
    b = real'($urandom_range(0, 20000)) - 10000.0;
    c = real'($urandom_range(0, 20000)) - 10000.0;
    d = real'($urandom_range(0, 20000)) - 10000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    q.x = 16'($rtoi(a / n * 16384.0));
    q.y = 16'($rtoi(b / n * 16384.0));
    q.z = 16'($rtoi(c / n * 16384.0));
    q.w = 16'($rtoi(d / n * 16384.0));
    return q;
  endfunction

  function automatic quat_t mk(int x, int y, int z, int w);
    quat_t q;
    q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.w = 16'(w);
    return q;
  endfunction

  // Append one word to the tail of the pending list
  function automatic void enqueue_quat(quat_t q);
    pending_quats.insert(pending_quats.size(), q);
  endfunction

  // Fill the queue of pending words: directed corners first, then random
  initial begin
    int h;
    h = 11585;  // half of sqrt(2) in Q1.14
    enqueue_quat(mk(0, 0, 0, 16384));       // identity
    enqueue_quat(mk(0, 0, 0, 0));           // all components zero, atan2 numerators zero
    enqueue_quat(mk(16384, 0, 0, 0));       // roll of pi, x operand negative
    enqueue_quat(mk(0, 0, 16384, 0));       // yaw of pi
    enqueue_quat(mk(0, h, 0, h));           // pitch at +90 degrees
    enqueue_quat(mk(0, -h, 0, h));          // pitch at -90 degrees
    enqueue_quat(mk(h, h, h, h));           // all components equal
    enqueue_quat(mk(-h, h, -h, h));
    enqueue_quat(mk(-32768, -32768, -32768, -32768));
    enqueue_quat(mk(32767, 32767, 32767, 32767));
    enqueue_quat(mk(-32768, 32767, -32768, 32767));
    enqueue_quat(mk(32767, -32768, 0, 32767));
    enqueue_quat(mk(16384, 16384, 16384, 16384));
    enqueue_quat(mk(-16384, -16384, -16384, -16384));
    enqueue_quat(mk(0, 16384, 0, 0));
    enqueue_quat(mk(0, 0, 0, -16384));
    enqueue_quat(mk(1, -1, 1, -1));
    enqueue_quat(mk(16384, 0, 0, -1));      // y = 0 with x negative side
    enqueue_quat(mk(-16384, 0, 0, 1));
    enqueue_quat(mk(h, 0, 0, h));
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(3) == 0)
        enqueue_quat(mk(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
      else
        enqueue_quat(rand_unit());
    end
  end

  // Release reset, then run the pressure phases
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold the receiver off for a long stretch while words keep coming
    wait (words_sent >= 200);
    @(posedge clk_i);
    hold_receiver <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_receiver <= 1'b0;
    // Pause the sender until the pipeline has drained
    wait (words_sent >= 600);
    @(posedge clk_i);
    hold_sender <= 1'b1;
    wait (expected_angles.size() == 0);
    @(posedge clk_i);
    hold_sender <= 1'b0;
  end

  // Driver: present one word at a time with random gaps
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_angles.insert(expected_angles.size(),
                               predict_angles(mk(quat_x_i, quat_y_i, quat_z_i, quat_w_i)));
        words_sent++;
        send_gap = gap_len();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0 || hold_sender || pending_quats.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i <= 1'b0;
          if (pending_quats.size() == 0) stimulus_done = 1'b1;
        end else begin
          quat_t q;
          q = pending_quats.pop_front();
          quat_x_i <= q.x; quat_y_i <= q.y; quat_z_i <= q.z; quat_w_i <= q.w;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each accepted word against the oldest prediction
  int recv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected output word: roll %0d pitch %0d yaw %0d",
                 roll_angle_o, pitch_angle_o, yaw_angle_o);
          fail_count++;
        end else begin
          euler_t e;
          e = expected_angles.pop_front();
          if (e.roll !== roll_angle_o) begin
            $error("roll_angle: expected %0d, actual %0d", e.roll, roll_angle_o);
            fail_count++;
          end
          if (e.pitch !== pitch_angle_o) begin
            $error("pitch_angle: expected %0d, actual %0d", e.pitch, pitch_angle_o);
            fail_count++;
          end
          if (e.yaw !== yaw_angle_o) begin
            $error("yaw_angle: expected %0d, actual %0d", e.yaw, yaw_angle_o);
            fail_count++;
          end
        end
        words_checked++;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (hold_receiver) begin
        out_ready_i <= 1'b0;
      end else begin
        recv_gap = gap_len();
        out_ready_i <= 1'b1;
      end
    end
  end

  // Wait for the drain, then report
  initial begin
    wait (stimulus_done && !in_valid_i && expected_angles.size() == 0);
    repeat (Stages + 60) @(posedge clk_i);
    $display("Sent %0d quaternions, checked %0d angle words,", words_sent, words_checked);
    $display("including corners, non-unit inputs and back-pressure stalls.");
    if (fail_count == 0 && expected_angles.size() == 0) begin
      $display("quaternion_to_euler_unit: match");
    end else begin
      $display("quaternion_to_euler_unit: mismatch");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2ms;
    $display("quaternion_to_euler_unit: mismatch");
    $finish;
  end

endmodule

FILE: files.f
design/qte_pkg.sv
design/qte_front.sv
design/qte_queue.sv
design/qte_sqrt.sv
design/qte_cordic.sv
design/qte_delay.sv
design/quaternion_to_euler_unit.sv
dv/testbench.sv
